>>> rtl/core/grrg_pkg.sv
// ----------------------------------------------------------------------------
// grrg_pkg
// Font table, character codes, register indexes and the run finder shared by
// the glyph run rectangle generator.
// ----------------------------------------------------------------------------
package grrg_pkg;

   localparam int GLYPH_COUNT = 42;
   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_BITS  = 6;
   localparam int ROW_BITS    = 3;
   localparam int COL_BITS    = 3;

   localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(GLYPH_ROWS - 1);

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 15;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCALE       = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ORIGIN_X    = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ORIGIN_Y    = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WIDTH_LIMIT = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SHADE       = 3'd4;

   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_CASE_OFFSET = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   localparam logic [GLYPH_BITS-1:0] GL_LETTER_BASE = 6'd10;
   localparam logic [GLYPH_BITS-1:0] GL_PLUS        = 6'd36;
   localparam logic [GLYPH_BITS-1:0] GL_MINUS       = 6'd37;
   localparam logic [GLYPH_BITS-1:0] GL_PERIOD      = 6'd38;
   localparam logic [GLYPH_BITS-1:0] GL_SLASH       = 6'd39;
   localparam logic [GLYPH_BITS-1:0] GL_COLON       = 6'd40;
   localparam logic [GLYPH_BITS-1:0] GL_PERCENT     = 6'd41;

   localparam logic [GLYPH_COLS-1:0] FONT_ROM [GLYPH_COUNT][GLYPH_ROWS] = '{
      '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
      '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
      '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
      '{5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E},
      '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
      '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
      '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0F},
      '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
      '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
      '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
      '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
      '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
      '{5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00},
      '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
      '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
      '{5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10},
      '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
      '{5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13}
   };

   typedef struct packed {
      logic                  valid;
      logic [GLYPH_BITS-1:0] idx;
   } glyph_sel_type;

   typedef struct packed {
      logic [COL_BITS-1:0]   start;
      logic [COL_BITS-1:0]   len;
      logic [GLYPH_COLS-1:0] rest;
   } run_type;

   function automatic glyph_sel_type glyph_lookup(logic [7:0] code);
      logic [7:0]    c;
      glyph_sel_type g;
      c = code;
      g = '0;
      if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) c = c - CH_CASE_OFFSET;
      if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
         g.valid = 1'b1;
         g.idx   = GLYPH_BITS'(c - CH_DIGIT_0);
      end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         g.valid = 1'b1;
         g.idx   = GLYPH_BITS'(c - CH_UPPER_A) + GL_LETTER_BASE;
      end else begin
         g.valid = 1'b1;
         case (c)
            CH_PLUS:    g.idx = GL_PLUS;
            CH_MINUS:   g.idx = GL_MINUS;
            CH_PERIOD:  g.idx = GL_PERIOD;
            CH_SLASH:   g.idx = GL_SLASH;
            CH_COLON:   g.idx = GL_COLON;
            CH_PERCENT: g.idx = GL_PERCENT;
            default:    g.valid = 1'b0;
         endcase
      end
      return g;
   endfunction

   // highest row with any dot set
   function automatic logic [ROW_BITS-1:0] glyph_last_row(logic [GLYPH_BITS-1:0] g);
      logic [ROW_BITS-1:0] r;
      r = '0;
      for (int i = 0; i < GLYPH_ROWS; i++) begin
         if (FONT_ROM[g][i] != '0) r = ROW_BITS'(i);
      end
      return r;
   endfunction

   // leftmost run of set dots; msb is the leftmost column
   function automatic run_type find_run(logic [GLYPH_COLS-1:0] bits);
      run_type r;
      logic    found;
      logic    ended;
      r      = '0;
      r.rest = bits;
      found  = 1'b0;
      ended  = 1'b0;
      for (int c = 0; c < GLYPH_COLS; c++) begin
         if (bits[GLYPH_COLS-1-c]) begin
            if (!found) begin
               found   = 1'b1;
               r.start = COL_BITS'(c);
            end
            if (!ended) begin
               r.len = r.len + COL_BITS'(1);
               r.rest[GLYPH_COLS-1-c] = 1'b0;
            end
         end else if (found) begin
            ended = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/glyph_run_rect_generator_top.sv
// ----------------------------------------------------------------------------
// glyph_run_rect_generator_top
// Turns a text string, one character per transfer, into filled rectangles:
// one per horizontal run of dots of a 5x7 font glyph, scaled by a register.
//
//   channel | ports                          | direction
//   req     | req_valid/ready, char, start   | in,  one character
//   rsp     | rsp_valid/ready, rect fields   | out, one rectangle
//   csr     | csr_we, csr_addr, csr_wdata    | in,  register write
//
// A drawn character passes through the check, fetch, load and scan states;
// the scanner steps through the glyph rows up to the last dotted row. A
// skipped or blank one goes from check back to idle. The font ROM is read
// one row ahead of the scanned row, and the run scanner emits one rectangle
// per cycle, but holds while the output register is full and not taken.
// Reset loads the register defaults and clears the pen and suppress flag.
// ----------------------------------------------------------------------------
module glyph_run_rect_generator_top
   import grrg_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_char_code,
   input  logic                     req_string_start,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [15:0]       rsp_rect_x,
   output logic signed [15:0]       rsp_rect_y,
   output logic [6:0]               rsp_rect_width,
   output logic [3:0]               rsp_rect_height,
   output logic [7:0]               rsp_rect_gray,
   output logic                     rsp_last,

   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CMP_BITS = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;
   localparam logic signed [CMP_BITS-1:0] PEN_MAX =
      CMP_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [CMP_BITS-1:0] PEN_MIN = -PEN_MAX - CMP_BITS'(1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_SCAN  = 3'd4;

   logic [3:0]                scale_ff;
   logic signed [14:0]        origin_x_ff;
   logic signed [14:0]        origin_y_ff;
   logic [13:0]               wl_ff;
   logic [7:0]                shade_ff;

   logic [2:0]                state_ff,    state_in;
   logic signed [COORD_BITS-1:0] pen_ff,   pen_in;
   logic                      susp_ff,     susp_in;
   logic [7:0]                code_ff,     code_in;
   logic [GLYPH_BITS-1:0]     glyph_ff,    glyph_in;
   logic [ROW_BITS-1:0]       last_row_ff, last_row_in;
   logic [ROW_BITS-1:0]       row_ff,      row_in;
   logic [GLYPH_COLS-1:0]     bits_ff,     bits_in;
   logic [GLYPH_COLS-1:0]     rom_q_ff;
   logic [ROW_BITS-1:0]       rd_row;

   logic                      rsp_valid_ff;
   logic signed [15:0]        rect_x_ff,   rect_x_in;
   logic signed [15:0]        rect_y_ff,   rect_y_in;
   logic [6:0]                rect_w_ff,   rect_w_in;
   logic [3:0]                rect_h_ff;
   logic [7:0]                rect_g_ff;
   logic                      last_ff,     last_in;

   logic                      emit;
   logic                      out_free;
   run_type                   run;
   glyph_sel_type             look;
   logic [6:0]                five_s, six_s, start_s, row_s;
   logic signed [CMP_BITS-1:0] pen_ext, origin_x_ext, reach, limit, pen_adv;
   logic signed [COORD_BITS-1:0] pen_step, pen_origin;
   logic signed [CMP_BITS-1:0] rect_x_full, rect_y_full;

   function automatic logic signed [COORD_BITS-1:0] pen_sat(
      logic signed [CMP_BITS-1:0] v);
      logic signed [CMP_BITS-1:0] c;
      c = v;
      if (v > PEN_MAX) c = PEN_MAX;
      if (v < PEN_MIN) c = PEN_MIN;
      return c[COORD_BITS-1:0];
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= 4'd1;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         wl_ff       <= '0;
         shade_ff    <= 8'hFF;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SCALE:       scale_ff    <= csr_wdata[3:0];
            CSR_ORIGIN_X:    origin_x_ff <= $signed(csr_wdata[14:0]);
            CSR_ORIGIN_Y:    origin_y_ff <= $signed(csr_wdata[14:0]);
            CSR_WIDTH_LIMIT: wl_ff       <= csr_wdata[13:0];
            CSR_SHADE:       shade_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign five_s  = 7'(scale_ff * 7'd5);
   assign six_s   = 7'(scale_ff * 7'd6);
   assign start_s = 7'(run.start * scale_ff);
   assign row_s   = 7'(row_ff * scale_ff);

   assign pen_ext      = CMP_BITS'(pen_ff);
   assign origin_x_ext = CMP_BITS'(origin_x_ff);
   assign reach        = pen_ext + CMP_BITS'($signed({1'b0, five_s}));
   assign limit        = origin_x_ext + CMP_BITS'($signed({1'b0, wl_ff}));
   assign pen_adv      = pen_ext + CMP_BITS'($signed({1'b0, six_s}));
   assign pen_step     = pen_sat(pen_adv);
   assign pen_origin   = pen_sat(origin_x_ext);

   assign run  = find_run(bits_ff);
   assign look = glyph_lookup(code_ff);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   assign rect_x_full = pen_ext + CMP_BITS'($signed({1'b0, start_s}));
   assign rect_y_full = CMP_BITS'(origin_y_ff) + CMP_BITS'($signed({1'b0, row_s}));
   assign rect_x_in   = rect_x_full[15:0];
   assign rect_y_in   = rect_y_full[15:0];
   assign rect_w_in   = 7'(run.len * scale_ff);
   assign last_in     = (run.rest == '0) && (row_ff == last_row_ff);

   always_comb begin
      state_in    = state_ff;
      pen_in      = pen_ff;
      susp_in     = susp_ff;
      code_in     = code_ff;
      glyph_in    = glyph_ff;
      last_row_in = last_row_ff;
      row_in      = row_ff;
      bits_in     = bits_ff;
      emit        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in  = req_char_code;
               state_in = ST_CHECK;
               if (req_string_start) begin
                  pen_in  = pen_origin;
                  susp_in = 1'b0;
               end
            end
         end
         ST_CHECK: begin
            state_in = ST_IDLE;
            if (scale_ff != '0 && wl_ff != '0 && !susp_ff) begin
               if (reach > limit) begin
                  susp_in = 1'b1;
               end else if (!look.valid) begin
                  pen_in = pen_step;
               end else begin
                  glyph_in    = look.idx;
                  last_row_in = glyph_last_row(look.idx);
                  row_in      = '0;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            bits_in  = rom_q_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (bits_ff == '0) begin
               row_in  = row_ff + ROW_BITS'(1);
               bits_in = rom_q_ff;
            end else if (out_free) begin
               emit    = 1'b1;
               bits_in = run.rest;
               if (last_in) begin
                  pen_in   = pen_step;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // font ROM read: one row ahead of the row being scanned, row 0 in fetch, held at the last row
   always_comb begin
      if (state_ff == ST_FETCH) begin
         rd_row = '0;
      end else if (row_in == ROW_LAST) begin
         rd_row = ROW_LAST;
      end else begin
         rd_row = row_in + ROW_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= FONT_ROM[glyph_ff][rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pen_ff   <= '0;
         susp_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pen_ff   <= pen_in;
         susp_ff  <= susp_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      glyph_ff    <= glyph_in;
      last_row_ff <= last_row_in;
      row_ff      <= row_in;
      bits_ff     <= bits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rect_x_ff <= rect_x_in;
         rect_y_ff <= rect_y_in;
         rect_w_ff <= rect_w_in;
         rect_h_ff <= scale_ff;
         rect_g_ff <= shade_ff;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rect_x      = rect_x_ff;
   assign rsp_rect_y      = rect_y_ff;
   assign rsp_rect_width  = rect_w_ff;
   assign rsp_rect_height = rect_h_ff;
   assign rsp_rect_gray   = rect_g_ff;
   assign rsp_last        = last_ff;

`ifndef SYNTHESIS
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CHECK))
      else $error("accepted character did not enter check");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("rectangle overwrote an untaken result");

   a_last_ends_char: assert property (@(posedge clock) disable iff (reset)
      (emit && last_in) |=> (state_ff == ST_IDLE))
      else $error("scanner kept running after the last rectangle");

   a_idle_pen_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_valid) |=> $stable(pen_ff))
      else $error("pen moved while idle");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (row_ff <= last_row_ff))
      else $error("scan row ran past the last glyph row");
`endif

endmodule

>>> test/glyph_run_rect_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_run_rect_generator_top_tb
// Sends strings one character per transfer and checks every rectangle, field
// by field and in order, against a local model of the 5x7 font, the run scan
// and the pen and suppress state. Directed strings cover every glyph class,
// case folding, blank and high codes, both ways of disabling output,
// suppression and its clearing at string start. Random strings follow under
// random register settings and random gaps on both channels, with one long
// output stall and a pen walk up to its saturation point.
// ----------------------------------------------------------------------------
module glyph_run_rect_generator_top_tb
   import grrg_pkg::*;
();

   localparam int HALF_PERIOD  = 4;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_PRINTS   = 40;
   localparam int PEN_MAX      = 32767;
   localparam int PEN_MIN      = -32768;
   localparam int COLS         = 5;
   localparam int ROWS         = 7;
   localparam int PEN_STEP     = 6;
   localparam int GLYPH_TOTAL  = 42;

   // characters in font order
   localparam logic [8*GLYPH_TOTAL-1:0] GLYPH_CHARS =
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ+-./:%";

   localparam logic [COLS-1:0] FONT_DOTS [GLYPH_TOTAL][ROWS] = '{
      '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
      '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
      '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
      '{5'h1E, 5'h01, 5'h01, 5'h06, 5'h01, 5'h01, 5'h1E},
      '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
      '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
      '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E},
      '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0F},
      '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
      '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
      '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
      '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
      '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
      '{5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00},
      '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
      '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
      '{5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10},
      '{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
      '{5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13}
   };

   typedef struct packed {
      logic [7:0] code;
      logic       start;
   } char_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [6:0]         width;
      logic [3:0]         height;
      logic [7:0]         gray;
      logic               last;
   } rect_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_char_code    = '0;
   logic                     req_string_start = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic signed [15:0]       rsp_rect_x;
   logic signed [15:0]       rsp_rect_y;
   logic [6:0]               rsp_rect_width;
   logic [3:0]               rsp_rect_height;
   logic [7:0]               rsp_rect_gray;
   logic                     rsp_last;
   logic                     csr_we           = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr         = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata        = '0;

   // register shadows and pen state
   int         reg_scale       = 1;
   int         reg_origin_x    = 0;
   int         reg_origin_y    = 0;
   int         reg_width_limit = 0;
   logic [7:0] reg_shade       = 8'hFF;
   int         pen_x           = 0;
   logic       string_muted    = 1'b0;

   char_type chars_pending[$];
   rect_type rects_due[$];

   int    chars_queued   = 0;
   int    chars_accepted = 0;
   int    rects_seen     = 0;
   int    mismatches     = 0;
   int    cycles         = 0;

   logic  tx_gaps  = 1'b0;
   logic  rx_gaps  = 1'b0;
   logic  hold_req = 1'b0;

   char_type tx_item;
   int    tx_wait   = 0;
   int    rx_wait   = 0;
   int    rx_hold   = 0;
   logic  hold_used = 1'b0;

   glyph_run_rect_generator_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rect_x       (rsp_rect_x),
      .rsp_rect_y       (rsp_rect_y),
      .rsp_rect_width   (rsp_rect_width),
      .rsp_rect_height  (rsp_rect_height),
      .rsp_rect_gray    (rsp_rect_gray),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int glyph_index(input logic [7:0] code);
      logic [7:0] c;
      int         g;
      c = code;
      g = -1;
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CH_CASE_OFFSET;
      for (int i = 0; i < GLYPH_TOTAL; i++) begin
         if (GLYPH_CHARS[8*(GLYPH_TOTAL-1-i) +: 8] == c) g = i;
      end
      return g;
   endfunction

   function automatic int pen_sat(input int v);
      if (v > PEN_MAX) return PEN_MAX;
      if (v < PEN_MIN) return PEN_MIN;
      return v;
   endfunction

   // expected rectangles of one character, one per run of dots
   task automatic draw_char(input char_type item);
      int       g;
      int       s;
      int       run0;
      int       len;
      logic     on;
      logic     have_prev;
      rect_type prev;
      s         = reg_scale;
      run0      = 0;
      have_prev = 1'b0;
      prev      = '0;
      if (item.start) begin
         pen_x        = pen_sat(reg_origin_x);
         string_muted = 1'b0;
      end
      if (s == 0 || reg_width_limit == 0 || string_muted) return;
      if (pen_x + COLS * s > reg_origin_x + reg_width_limit) begin
         string_muted = 1'b1;
         return;
      end
      g = glyph_index(item.code);
      if (g >= 0) begin
         for (int row = 0; row < ROWS; row++) begin
            len = 0;
            for (int col = 0; col <= COLS; col++) begin
               on = 1'b0;
               if (col < COLS) on = FONT_DOTS[g][row][COLS-1-col];
               if (on) begin
                  if (len == 0) run0 = col;
                  len++;
               end else if (len != 0) begin
                  if (have_prev) rects_due.push_back(prev);
                  prev.x      = 16'(pen_x + run0 * s);
                  prev.y      = 16'(reg_origin_y + row * s);
                  prev.width  = 7'(len * s);
                  prev.height = 4'(s);
                  prev.gray   = reg_shade;
                  prev.last   = 1'b0;
                  have_prev   = 1'b1;
                  len         = 0;
               end
            end
         end
         if (have_prev) begin
            prev.last = 1'b1;
            rects_due.push_back(prev);
         end
      end
      pen_x = pen_sat(pen_x + PEN_STEP * s);
   endtask

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("[%0t] %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report($sformatf("rect %0d %s: got %0d, expected %0d", rects_seen, name, got, want));
      end
   endtask

   task automatic check_rect();
      rect_type want;
      if (rects_due.size() == 0) begin
         report($sformatf("rect %0d at x %0d y %0d with nothing expected",
                          rects_seen, rsp_rect_x, rsp_rect_y));
      end else begin
         want = rects_due.pop_front();
         if ({rsp_rect_x, rsp_rect_y, rsp_rect_width, rsp_rect_height, rsp_rect_gray,
              rsp_last} !== want) begin
            check_field("x", int'(rsp_rect_x), int'($signed(want.x)));
            check_field("y", int'(rsp_rect_y), int'($signed(want.y)));
            check_field("width", int'(rsp_rect_width), int'(want.width));
            check_field("height", int'(rsp_rect_height), int'(want.height));
            check_field("gray", int'(rsp_rect_gray), int'(want.gray));
            check_field("last", int'(rsp_last), int'(want.last));
            if ($isunknown({rsp_rect_x, rsp_rect_y, rsp_rect_width, rsp_rect_height,
                            rsp_rect_gray, rsp_last})) begin
               report($sformatf("rect %0d has unknown bits", rects_seen));
            end
         end
      end
      rects_seen++;
   endtask

   // character driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            draw_char(tx_item);
            chars_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (tx_wait != 0 || chars_pending.size() == 0) begin
               if (tx_wait != 0) tx_wait--;
               req_valid <= 1'b0;
            end else begin
               tx_item = chars_pending.pop_front();
               req_valid        <= 1'b1;
               req_char_code    <= tx_item.code;
               req_string_start <= tx_item.start;
               tx_wait = tx_gaps ? $urandom_range(0, 7) : 0;
            end
         end
      end
   end

   // rectangle monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   = 0;
         rx_hold   = 0;
         hold_used = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_rect();
            rx_wait = rx_gaps ? $urandom_range(0, 7) : 0;
         end
         if (hold_req && !hold_used) begin
            rx_hold   = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (!hold_req) hold_used = 1'b0;
         if (rx_hold != 0) begin
            rx_hold--;
            rsp_ready <= 1'b0;
         end else if (rx_wait != 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] idx, input int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      case (idx)
         CSR_SCALE:       reg_scale       = int'(value[3:0]);
         CSR_ORIGIN_X:    reg_origin_x    = int'($signed(value[14:0]));
         CSR_ORIGIN_Y:    reg_origin_y    = int'($signed(value[14:0]));
         CSR_WIDTH_LIMIT: reg_width_limit = int'(value[13:0]);
         CSR_SHADE:       reg_shade       = value[7:0];
         default:         ;
      endcase
   endtask

   task automatic program_regs(input int sc, input int ox, input int oy, input int lim,
                               input int gray);
      csr_write(CSR_SCALE, sc);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_WIDTH_LIMIT, lim);
      csr_write(CSR_SHADE, gray);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic begin_phase(input logic tx, input logic rx);
      @(negedge clock);
      tx_gaps = tx;
      rx_gaps = rx;
   endtask

   // wait for every character and rectangle, then let blank or skipped
   // characters still in the block run out
   task automatic drain();
      @(negedge clock);
      while (chars_accepted != chars_queued || rects_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_char(input logic [7:0] code, input logic start);
      char_type item;
      item.code  = code;
      item.start = start;
      chars_pending.push_back(item);
      chars_queued++;
   endtask

   task automatic queue_text(input string text);
      for (int i = 0; i < text.len(); i++) queue_char(text[i], i == 0);
   endtask

   function automatic logic [7:0] pick_char();
      logic [7:0] c;
      if ($urandom_range(0, 9) < 7) begin
         c = GLYPH_CHARS[8*$urandom_range(0, GLYPH_TOTAL-1) +: 8];
         if (c >= CH_UPPER_A && c <= CH_UPPER_Z && $urandom_range(0, 1) == 1) begin
            c = c + CH_CASE_OFFSET;
         end
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   task automatic queue_string(input int n, input logic fresh);
      for (int i = 0; i < n; i++) queue_char(pick_char(), fresh && i == 0);
   endtask

   initial begin
      int n;
      int sc;
      int lim;
      int oy;
      int gray;
      int r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // after reset the zero width limit keeps the block silent
      begin_phase(1'b0, 1'b0);
      queue_char("A", 1'b1);
      queue_char(8'hFF, 1'b0);
      drain();

      program_regs(1, 0, 0, 16383, 255);
      begin_phase(1'b0, 1'b0);
      queue_text("09AZaz+-./:% ");
      queue_char(8'h80, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char("W", 1'b0);
      drain();

      // narrow limit: one glyph fits, the rest is cut until the next string
      program_regs(15, -16384, 16383, 100, 0);
      begin_phase(1'b1, 1'b1);
      queue_char("W", 1'b1);
      queue_char("%", 1'b0);
      queue_char("8", 1'b0);
      queue_char("8", 1'b1);
      drain();

      program_regs(0, 16383, -16384, 16383, 255);
      begin_phase(1'b1, 1'b0);
      queue_char("A", 1'b1);
      queue_char("B", 1'b0);
      drain();

      program_regs(4, 0, 0, 0, 7);
      begin_phase(1'b0, 1'b1);
      queue_char("C", 1'b1);
      drain();

      // pen walk: 181 wide steps, 13 unit steps, then a step past the top
      oy   = $urandom_range(0, 32767);
      gray = $urandom_range(0, 255);
      program_regs(15, 16383, oy, 16383, gray);
      begin_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      queue_string(181, 1'b1);
      drain();
      program_regs(1, 16383, oy, 16383, gray);
      begin_phase(1'b0, 1'b1);
      queue_string(13, 1'b0);
      drain();
      program_regs(3, 16383, oy, 16383, gray);
      begin_phase(1'b1, 1'b0);
      queue_string(3, 1'b0);
      drain();

      for (int p = 0; p < 4; p++) begin
         sc = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 15);
         r  = $urandom_range(0, 9);
         if (r == 0) lim = 0;
         else if (r < 3) lim = $urandom_range(0, 16383);
         else lim = ($urandom_range(1, 12) * PEN_STEP + COLS) * sc + $urandom_range(0, 7);
         if (p == 2) begin
            sc  = $urandom_range(1, 3);
            lim = 16383;
         end
         program_regs(sc, $urandom_range(0, 32767), $urandom_range(0, 32767), lim,
                      $urandom_range(0, 255));
         if (p == 2) begin
            begin_phase(1'b0, 1'b0);
            hold_req = 1'b1;
         end else begin
            begin_phase(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         n = 0;
         while (n < 12) begin
            r = $urandom_range(1, 8);
            queue_string(r, 1'b1);
            n = n + r;
            if ($urandom_range(0, 4) == 0) begin
               queue_char(pick_char(), 1'($urandom_range(0, 1)));
               n++;
            end
         end
         drain();
         hold_req = 1'b0;
      end

      if (mismatches == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> files.f
rtl/core/grrg_pkg.sv
rtl/core/glyph_run_rect_generator_top.sv
test/glyph_run_rect_generator_top_tb.sv
